>>> design/fmpi_pkg.sv
// Shared types, codes and the sine/cosine quarter-table function for the FM modulator.
package fmpi_pkg;

    localparam logic [1:0] MODE_SAMPLE = 2'd0;
    localparam logic [1:0] MODE_STAP   = 2'd1;
    localparam logic [1:0] MODE_ITAP   = 2'd2;

    localparam logic [1:0] REG_MOD_GAIN   = 2'd0;
    localparam logic [1:0] REG_INTERP     = 2'd1;
    localparam logic [1:0] REG_SHAPE_TAPS = 2'd2;

    localparam logic [15:0] MOD_GAIN_RST   = 16'd1024;
    localparam logic [4:0]  INTERP_RST     = 5'd1;
    localparam logic [6:0]  SHAPE_TAPS_RST = 7'd64;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    typedef struct packed {
        logic en;
        logic rot;
    } t_cell_ctl;

    function automatic logic [15:0] q30_to_q15(input logic signed [63:0] v);
        logic [63:0] r;
        if (v < 0) begin
            return 16'd0;
        end
        r = (64'(v) + 64'd16384) >> 15;
        if (r > 64'd32767) begin
            r = 64'd32767;
        end
        return r[15:0];
    endfunction

    // First-quadrant entry: {cos, sin} in Q1.15 for an angle of r / 2^30 quarter.
    function automatic logic [31:0] sc_entry(input logic [29:0] r);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic signed [63:0] s;
        logic signed [63:0] c;
        x  = (64'(r) * HALF_PI_Q30) >> 30;
        x2 = (x * x) >> 30;
        t = x;
        s = $signed(t);
        t = ((t * x2) >> 30) / 64'd6;   s = s - $signed(t);
        t = ((t * x2) >> 30) / 64'd20;  s = s + $signed(t);
        t = ((t * x2) >> 30) / 64'd42;  s = s - $signed(t);
        t = ((t * x2) >> 30) / 64'd72;  s = s + $signed(t);
        t = ((t * x2) >> 30) / 64'd110; s = s - $signed(t);
        t = ((t * x2) >> 30) / 64'd156; s = s + $signed(t);
        t = 64'd1 << 30;
        c = $signed(t);
        t = ((t * x2) >> 30) / 64'd2;   c = c - $signed(t);
        t = ((t * x2) >> 30) / 64'd12;  c = c + $signed(t);
        t = ((t * x2) >> 30) / 64'd30;  c = c - $signed(t);
        t = ((t * x2) >> 30) / 64'd56;  c = c + $signed(t);
        t = ((t * x2) >> 30) / 64'd90;  c = c - $signed(t);
        t = ((t * x2) >> 30) / 64'd132; c = c + $signed(t);
        t = ((t * x2) >> 30) / 64'd182; c = c - $signed(t);
        return {q30_to_q15(c), q30_to_q15(s)};
    endfunction

endpackage

>>> design/fmpi_in_if.sv
// Input request channel: mode, tap write fields and message sample.
interface fmpi_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         mode;
    logic [6:0]         tap_index;
    logic signed [17:0] tap_value;
    logic signed [15:0] sample;

    modport source (output valid, mode, tap_index, tap_value, sample, input ready);
    modport sink   (input valid, mode, tap_index, tap_value, sample, output ready);
endinterface

>>> design/fmpi_out_if.sv
// Output request channel: complex interpolated sample and run-end flag.
interface fmpi_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] i_out;
    logic signed [15:0] q_out;
    logic               last;

    modport source (output valid, i_out, q_out, last, input ready);
    modport sink   (input valid, i_out, q_out, last, output ready);
endinterface

>>> design/fmpi_ram.sv
// Generic single-write, single-read RAM with registered read data.
module fmpi_ram #(
    parameter int W = 18,
    parameter int D = 64
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);
    logic [W-1:0] r_mem [D];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

>>> design/fmpi_cell.sv
// One history cell: shifts in from the left neighbor or rotates in from the right.
module fmpi_cell #(
    parameter int W = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  fmpi_pkg::t_cell_ctl i_ctl,
    input  logic [W-1:0]        i_left,
    input  logic [W-1:0]        i_right,
    output logic [W-1:0]        o_q
);
    import fmpi_pkg::*;

    logic [W-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q <= '0;
        end else if (i_ctl.en) begin
            r_q <= i_ctl.rot ? i_right : i_left;
        end
    end

    assign o_q = r_q;
endmodule

>>> design/fm_modulator_polyphase_interp.sv
// Top level of the FM modulator with shaping FIR and polyphase interpolator.
//
// Input channel i_in takes one request at a time: mode 1 and 2 write a shaping or
// interpolator tap (no output), mode 0 is a message sample, mode 3 is dropped. Output
// channel o_out carries interp_factor complex samples per message
// sample, last set on the final one. Registers sit on an APB port, pready tied high.
// A message sample passes through the shaping FIR, phase and sine table stages, then
// through each interpolator branch in turn: both histories are rings of cells that
// rotate past their multiply-accumulate, one tap per cycle.
// The output register lets a branch finish while the previous result waits; a
// stalled receiver holds the next branch in its output stage and i_in stays low.
// Reset (synchronous, active low) clears histories and phase, sets the registers to their
// defaults and clears the tap tables (through per-entry valid bits); the block is ready in the first cycle after.
module fm_modulator_polyphase_interp #(
    parameter int SHAPE_TAPS       = 64,
    parameter int MAX_INTERP       = 16,
    parameter int BRANCH_TAPS      = 8,
    parameter int SINE_TABLE_DEPTH = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    fmpi_in_if.sink     i_in,
    fmpi_out_if.source  o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import fmpi_pkg::*;

    localparam int SAW  = $clog2(SHAPE_TAPS);
    localparam int ITD  = MAX_INTERP * BRANCH_TAPS;
    localparam int TAW  = (ITD > 1) ? $clog2(ITD) : 1;
    localparam int JW   = (BRANCH_TAPS > 1) ? $clog2(BRANCH_TAPS) : 1;
    localparam int BW   = (MAX_INTERP > 1) ? $clog2(MAX_INTERP) : 1;
    localparam int LW   = $clog2(MAX_INTERP + 1) + 1;
    localparam int NW   = $clog2(SHAPE_TAPS + 1) + 1;
    localparam int FAW  = 34 + SAW + 1;
    localparam int IAW  = 34 + JW + 1;
    localparam int LD   = $clog2(SINE_TABLE_DEPTH);
    localparam int QTR  = SINE_TABLE_DEPTH / 4;
    localparam int RSH  = 32 - LD;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_FIR  = 4'd1;
    localparam logic [3:0] S_FDR  = 4'd2;
    localparam logic [3:0] S_MUL  = 4'd3;
    localparam logic [3:0] S_PH   = 4'd4;
    localparam logic [3:0] S_ROM  = 4'd5;
    localparam logic [3:0] S_CX   = 4'd6;
    localparam logic [3:0] S_BR   = 4'd7;
    localparam logic [3:0] S_BD   = 4'd8;
    localparam logic [3:0] S_OUT  = 4'd9;

    // configuration
    logic [15:0] r_gain;
    logic [4:0]  r_interp;
    logic [6:0]  r_ntaps;
    logic        w_pwr;

    assign pready = 1'b1;
    assign w_pwr  = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain   <= MOD_GAIN_RST;
            r_interp <= INTERP_RST;
            r_ntaps  <= SHAPE_TAPS_RST;
        end else if (w_pwr) begin
            unique case (paddr[3:2])
                REG_MOD_GAIN:   r_gain   <= pwdata[15:0];
                REG_INTERP:     r_interp <= pwdata[4:0];
                REG_SHAPE_TAPS: r_ntaps  <= pwdata[6:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_MOD_GAIN:   prdata = {16'd0, r_gain};
            REG_INTERP:     prdata = {27'd0, r_interp};
            REG_SHAPE_TAPS: prdata = {25'd0, r_ntaps};
            default:        prdata = '0;
        endcase
    end

    // clamped run lengths
    logic [LW-1:0] w_l;
    logic [NW-1:0] w_n;

    always_comb begin
        if (r_interp == 5'd0) begin
            w_l = LW'(1);
        end else if (LW'(r_interp) > LW'(MAX_INTERP)) begin
            w_l = LW'(MAX_INTERP);
        end else begin
            w_l = LW'(r_interp);
        end
        if (r_ntaps == 7'd0) begin
            w_n = NW'(1);
        end else if (NW'(r_ntaps) > NW'(SHAPE_TAPS)) begin
            w_n = NW'(SHAPE_TAPS);
        end else begin
            w_n = NW'(r_ntaps);
        end
    end

    // control state
    logic [3:0]     r_st;
    logic [SAW-1:0] r_k;
    logic [JW-1:0]  r_j;
    logic [BW-1:0]  r_b;
    logic [TAW-1:0] r_ta;
    logic           w_acc;
    logic           w_last;

    assign i_in.ready = (r_st == S_IDLE);
    assign w_acc      = i_in.valid & (r_st == S_IDLE);
    assign w_last     = (LW'(r_b) == w_l - LW'(1));

    // tap tables
    logic            w_swe;
    logic            w_iwe;
    logic [17:0]     w_srd;
    logic [17:0]     w_ird;
    logic            r_svld [SHAPE_TAPS];
    logic            r_ivld [ITD];
    logic            r_ssv;
    logic            r_isv;
    logic [SAW-1:0]  w_swa;
    logic [TAW-1:0]  w_iwa;

    assign w_swa = SAW'(i_in.tap_index);
    assign w_iwa = TAW'(i_in.tap_index);
    assign w_swe = w_acc && (i_in.mode == MODE_STAP) && (32'(i_in.tap_index) < SHAPE_TAPS);
    assign w_iwe = w_acc && (i_in.mode == MODE_ITAP) && (32'(i_in.tap_index) < ITD);

    fmpi_ram #(.W(18), .D(SHAPE_TAPS)) u_sram (
        .i_clk   (i_clk),
        .i_we    (w_swe),
        .i_waddr (w_swa),
        .i_wdata (i_in.tap_value),
        .i_raddr (r_k),
        .o_rdata (w_srd)
    );

    fmpi_ram #(.W(18), .D(ITD)) u_iram (
        .i_clk   (i_clk),
        .i_we    (w_iwe),
        .i_waddr (w_iwa),
        .i_wdata (i_in.tap_value),
        .i_raddr (r_ta),
        .o_rdata (w_ird)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int e = 0; e < SHAPE_TAPS; e++) r_svld[e] <= 1'b0;
            for (int e = 0; e < ITD; e++) r_ivld[e] <= 1'b0;
            r_ssv <= 1'b0;
            r_isv <= 1'b0;
        end else begin
            if (w_swe) r_svld[w_swa] <= 1'b1;
            if (w_iwe) r_ivld[w_iwa] <= 1'b1;
            r_ssv <= r_svld[r_k];
            r_isv <= r_ivld[r_ta];
        end
    end

    // shaping history ring: cell 0 holds the current sample
    t_cell_ctl   w_sctl;
    logic [15:0] w_sq [SHAPE_TAPS];

    assign w_sctl.en  = (w_acc && i_in.mode == MODE_SAMPLE) || (r_st == S_FIR);
    assign w_sctl.rot = (r_st == S_FIR);

    for (genvar g = 0; g < SHAPE_TAPS; g++) begin : g_scell
        fmpi_cell #(.W(16)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_sctl),
            .i_left  ((g == 0) ? i_in.sample : w_sq[(g == 0) ? 0 : g - 1]),
            .i_right (w_sq[(g == SHAPE_TAPS - 1) ? 0 : g + 1]),
            .o_q     (w_sq[g])
        );
    end

    // complex history ring: {i, q}, cell 0 newest
    t_cell_ctl   w_cctl;
    logic [31:0] w_cq [BRANCH_TAPS];
    logic [31:0] w_cnew;

    assign w_cctl.en  = (r_st == S_CX) || (r_st == S_BR);
    assign w_cctl.rot = (r_st == S_BR);

    for (genvar g = 0; g < BRANCH_TAPS; g++) begin : g_ccell
        fmpi_cell #(.W(32)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_cctl),
            .i_left  ((g == 0) ? w_cnew : w_cq[(g == 0) ? 0 : g - 1]),
            .i_right (w_cq[(g == BRANCH_TAPS - 1) ? 0 : g + 1]),
            .o_q     (w_cq[g])
        );
    end

    // sine/cosine quarter table
    logic [31:0] w_rom [QTR];

    for (genvar g = 0; g < QTR; g++) begin : g_rom
        assign w_rom[g] = sc_entry(30'(g << RSH));
    end

    // datapath registers
    logic signed [15:0]  r_xh;
    logic                r_fmv;
    logic                r_fuse;
    logic signed [FAW-1:0] r_facc;
    logic signed [56:0]  r_prod;
    logic [31:0]         r_phase;
    logic [31:0]         r_sc;
    logic [1:0]          r_quad;
    logic signed [15:0]  r_hi;
    logic signed [15:0]  r_hq;
    logic                r_imv;
    logic signed [IAW-1:0] r_ai;
    logic signed [IAW-1:0] r_aq;
    logic signed [17:0]  w_stap;
    logic signed [17:0]  w_itap;
    logic signed [15:0]  w_cc;
    logic signed [15:0]  w_ss;
    logic signed [15:0]  w_ci;
    logic signed [15:0]  w_cs;
    logic signed [15:0]  w_yi;
    logic signed [15:0]  w_yq;
    logic signed [IAW-1:0] w_ri;
    logic signed [IAW-1:0] w_rq;

    assign w_stap = r_ssv ? $signed(w_srd) : 18'sd0;
    assign w_itap = r_isv ? $signed(w_ird) : 18'sd0;
    assign w_cc   = $signed(r_sc[31:16]);
    assign w_ss   = $signed(r_sc[15:0]);

    always_comb begin
        unique case (r_quad)
            2'd0: begin w_ci = w_cc;  w_cs = w_ss;  end
            2'd1: begin w_ci = -w_ss; w_cs = w_cc;  end
            2'd2: begin w_ci = -w_cc; w_cs = -w_ss; end
            default: begin w_ci = w_ss; w_cs = -w_cc; end
        endcase
    end
    assign w_cnew = {w_ci, w_cs};

    // round half up by 2^17 and saturate
    assign w_ri = (r_ai + IAW'(65536)) >>> 17;
    assign w_rq = (r_aq + IAW'(65536)) >>> 17;

    always_comb begin
        if (w_ri > IAW'(32767))        w_yi = 16'sh7fff;
        else if (w_ri < -IAW'(32768))  w_yi = -16'sh8000;
        else                           w_yi = w_ri[15:0];
        if (w_rq > IAW'(32767))        w_yq = 16'sh7fff;
        else if (w_rq < -IAW'(32768))  w_yq = -16'sh8000;
        else                           w_yq = w_rq[15:0];
    end

    always_ff @(posedge i_clk) begin
        r_xh   <= $signed(w_sq[0]);
        r_fuse <= (NW'(r_k) < w_n);
        r_hi   <= $signed(w_cq[0][31:16]);
        r_hq   <= $signed(w_cq[0][15:0]);
        r_prod <= r_facc * $signed({1'b0, r_gain});
        r_sc   <= w_rom[r_phase[31-2:RSH]];
        r_quad <= r_phase[31:30];
        if (w_acc) begin
            r_facc <= '0;
        end else if (r_fmv && r_fuse) begin
            r_facc <= r_facc + FAW'(r_xh * w_stap);
        end
        if (r_st == S_CX || (r_st == S_OUT && (!o_out.valid || o_out.ready))) begin
            r_ai <= '0;
            r_aq <= '0;
        end else if (r_imv) begin
            r_ai <= r_ai + IAW'(r_hi * w_itap);
            r_aq <= r_aq + IAW'(r_hq * w_itap);
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= S_IDLE;
            r_k     <= '0;
            r_j     <= '0;
            r_b     <= '0;
            r_ta    <= '0;
            r_fmv   <= 1'b0;
            r_imv   <= 1'b0;
            r_phase <= '0;
            o_out.valid <= 1'b0;
        end else begin
            r_fmv <= (r_st == S_FIR);
            r_imv <= (r_st == S_BR);
            if (r_st == S_OUT && (!o_out.valid || o_out.ready)) begin
                o_out.valid <= 1'b1;
            end else if (o_out.valid && o_out.ready) begin
                o_out.valid <= 1'b0;
            end
            unique case (r_st)
                S_IDLE: begin
                    if (w_acc && i_in.mode == MODE_SAMPLE) begin
                        r_k  <= '0;
                        r_st <= S_FIR;
                    end
                end
                S_FIR: begin
                    r_k <= r_k + SAW'(1);
                    if (32'(r_k) == SHAPE_TAPS - 1) r_st <= S_FDR;
                end
                S_FDR: r_st <= S_MUL;
                S_MUL: r_st <= S_PH;
                S_PH: begin
                    r_phase <= r_phase + 32'(r_prod[47:16]);
                    r_st    <= S_ROM;
                end
                S_ROM: r_st <= S_CX;
                S_CX: begin
                    r_b  <= '0;
                    r_j  <= '0;
                    r_ta <= '0;
                    r_st <= S_BR;
                end
                S_BR: begin
                    r_ta <= TAW'(r_ta + TAW'(w_l));
                    r_j  <= r_j + JW'(1);
                    if (32'(r_j) == BRANCH_TAPS - 1) r_st <= S_BD;
                end
                S_BD: r_st <= S_OUT;
                S_OUT: begin
                    if (!o_out.valid || o_out.ready) begin
                        o_out.i_out <= w_yi;
                        o_out.q_out <= w_yq;
                        o_out.last  <= w_last;
                        if (w_last) begin
                            r_st <= S_IDLE;
                        end else begin
                            r_b  <= r_b + BW'(1);
                            r_ta <= TAW'(r_b) + TAW'(1);
                            r_j  <= '0;
                            r_st <= S_BR;
                        end
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule

>>> tb/sv/testbench.sv
// Self-checking testbench for the FM modulator with polyphase interpolator.
`timescale 1ns / 100ps

module testbench;
    import fmpi_pkg::*;

    localparam int NSHP      = 64;
    localparam int NINTERP   = 16;
    localparam int NBRANCH   = 8;
    localparam int NITAP     = NINTERP * NBRANCH;
    localparam int WDOG_MAX  = 4000;
    localparam int DRAIN_CYC = 300;

    typedef struct {
        logic signed [15:0] i_val;
        logic signed [15:0] q_val;
        logic               last;
    } iq_t;

    typedef struct {
        logic [1:0] mode;
        int         idx;
        int         tap;
        int         smp;
        bit         zero_out;   // taps still zero: output must be 0, 0, last
    } row_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel, penable, pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    fmpi_in_if  in_ch ();
    fmpi_out_if out_ch ();

    fm_modulator_polyphase_interp DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // predictor state
    logic [15:0]        gain_reg;
    logic [4:0]         interp_reg;
    logic [6:0]         ntaps_reg;
    logic signed [15:0] msg_hist [NSHP-1];
    logic signed [17:0] shape_coef [NSHP];
    logic signed [17:0] interp_coef [NITAP];
    logic [31:0]        phase;
    logic signed [15:0] cplx_i [NBRANCH];
    logic signed [15:0] cplx_q [NBRANCH];

    iq_t pending_iq[$];
    int  n_err;
    int  n_items;
    int  n_outputs;
    int  idle_cycles;
    bit  long_hold_req;
    bit  no_idle;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic logic signed [15:0] q30_round(input longint v);
        longint r;
        if (v < 0) begin
            return 16'sd0;
        end
        r = (v + 16384) >>> 15;
        if (r > 32767) begin
            r = 32767;
        end
        return 16'(r);
    endfunction

    // table lookup: phase quantized to 1024 steps, Taylor sin/cos in Q30
    task automatic phase_to_iq(input logic [31:0] ph,
                               output logic signed [15:0] c_o,
                               output logic signed [15:0] s_o);
        logic [31:0]  a;
        logic [63:0]  x, x2, t;
        longint       s, c;
        logic signed [15:0] sq, cq;
        a  = {ph[31:22], 22'd0};
        x  = (64'(a[29:0]) * 64'd1686629713) >> 30;
        x2 = (x * x) >> 30;
        t = x;
        s = longint'(t);
        for (int n = 1; n <= 11; n += 2) begin
            t = ((t * x2) >> 30) / 64'((n + 1) * (n + 2));
            if (((n + 1) / 2) % 2 == 1) s -= longint'(t); else s += longint'(t);
        end
        t = 64'd1 << 30;
        c = longint'(t);
        for (int n = 0; n <= 12; n += 2) begin
            t = ((t * x2) >> 30) / 64'((n + 1) * (n + 2));
            if (((n + 2) / 2) % 2 == 1) c -= longint'(t); else c += longint'(t);
        end
        sq = q30_round(s);
        cq = q30_round(c);
        case (a[31:30])
            2'd0: begin c_o = cq;  s_o = sq;  end
            2'd1: begin c_o = -sq; s_o = cq;  end
            2'd2: begin c_o = -cq; s_o = -sq; end
            default: begin c_o = sq; s_o = -cq; end
        endcase
    endtask

    function automatic logic signed [15:0] round_sat17(input longint acc);
        longint r;
        r = (acc + 65536) >>> 17;
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
        return 16'(r);
    endfunction

    // apply one accepted request to the model state and queue its outputs
    task automatic modulate(input logic [1:0] mode, input logic [6:0] idx,
                            input logic signed [17:0] tap, input logic signed [15:0] smp,
                            input bit zero_out);
        int     ntap, nb;
        longint acc, ai, aq, h;
        logic signed [15:0] ci, cs;
        iq_t    o;
        if (mode == MODE_STAP) begin
            if (idx < NSHP) shape_coef[idx] = tap;
            return;
        end
        if (mode == MODE_ITAP) begin
            interp_coef[idx] = tap;
            return;
        end
        if (mode != MODE_SAMPLE) return;
        ntap = (ntaps_reg == 0) ? 1 : (ntaps_reg > NSHP) ? NSHP : ntaps_reg;
        nb   = (interp_reg == 0) ? 1 : (interp_reg > NINTERP) ? NINTERP : interp_reg;
        acc = longint'(smp) * longint'(shape_coef[0]);
        for (int k = 1; k < ntap; k++)
            acc += longint'(msg_hist[k-1]) * longint'(shape_coef[k]);
        for (int k = NSHP - 2; k > 0; k--) msg_hist[k] = msg_hist[k-1];
        msg_hist[0] = smp;
        acc = (acc * longint'({1'b0, gain_reg})) >>> 16;
        phase = phase + 32'(acc);
        phase_to_iq(phase, ci, cs);
        for (int j = NBRANCH - 1; j > 0; j--) begin
            cplx_i[j] = cplx_i[j-1];
            cplx_q[j] = cplx_q[j-1];
        end
        cplx_i[0] = ci;
        cplx_q[0] = cs;
        for (int b = 0; b < nb; b++) begin
            ai = 0;
            aq = 0;
            for (int j = 0; j < NBRANCH; j++) begin
                h = (b + nb * j < NITAP) ? longint'(interp_coef[b + nb * j]) : 0;
                ai += h * longint'(cplx_i[j]);
                aq += h * longint'(cplx_q[j]);
            end
            o.i_val = zero_out ? 16'sd0 : round_sat17(ai);
            o.q_val = zero_out ? 16'sd0 : round_sat17(aq);
            o.last  = (b == nb - 1);
            pending_iq.push_back(o);
        end
    endtask

    task automatic reg_write(input logic [1:0] reg_idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (reg_idx)
            REG_MOD_GAIN: gain_reg   = val[15:0];
            REG_INTERP:   interp_reg = val[4:0];
            default:      ntaps_reg  = val[6:0];
        endcase
    endtask

    task automatic send(input logic [1:0] mode, input logic [6:0] idx,
                        input logic signed [17:0] tap, input logic signed [15:0] smp,
                        input bit zero_out);
        int gap;
        in_ch.valid     <= 1'b1;
        in_ch.mode      <= mode;
        in_ch.tap_index <= idx;
        in_ch.tap_value <= tap;
        in_ch.sample    <= smp;
        do @(posedge i_clk); while (!in_ch.ready);
        modulate(mode, idx, tap, smp, zero_out);
        n_items++;
        gap = $urandom_range(0, 99);
        if (!no_idle && gap >= 60) begin
            in_ch.valid <= 1'b0;
            repeat ((gap < 92) ? $urandom_range(1, 3) : $urandom_range(10, 40))
                @(posedge i_clk);
        end
    endtask

    // wait for the block to drain before touching the registers
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (pending_iq.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
    endtask

    // receiver side: random ready, short and long holds, one very long hold
    initial begin
        int hold;
        out_ch.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (long_hold_req) begin
                out_ch.ready <= 1'b0;
                repeat (600) @(posedge i_clk);
                long_hold_req = 1'b0;
            end else if (no_idle) begin
                out_ch.ready <= 1'b1;
                @(posedge i_clk);
            end else begin
                hold = $urandom_range(0, 99);
                out_ch.ready <= (hold >= 20);
                if (hold < 2) repeat ($urandom_range(20, 80)) @(posedge i_clk);
                else @(posedge i_clk);
            end
        end
    end

    // output checker and watchdog
    always @(posedge i_clk) begin
        iq_t e;
        if (!i_rst_n) begin
            idle_cycles <= 0;
        end else begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || psel)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WDOG_MAX) begin
                $display("%0t: watchdog, no progress for %0d cycles", $time, WDOG_MAX);
                $display("CHECKS FAILED");
                $finish;
            end
            if (out_ch.valid && out_ch.ready) begin
                n_outputs++;
                if (pending_iq.size() == 0) begin
                    n_err++;
                    $display("%0t: unexpected output i=%0d q=%0d last=%0b", $time,
                             out_ch.i_out, out_ch.q_out, out_ch.last);
                end else begin
                    e = pending_iq.pop_front();
                    if (out_ch.i_out !== e.i_val || out_ch.q_out !== e.q_val
                            || out_ch.last !== e.last) begin
                        n_err++;
                        $display("%0t: mismatch expected i=%0d q=%0d last=%0b, got i=%0d q=%0d last=%0b",
                                 $time, e.i_val, e.q_val, e.last,
                                 out_ch.i_out, out_ch.q_out, out_ch.last);
                    end
                end
            end
        end
    end

    row_t dir_rows [18] = '{
        '{MODE_SAMPLE, 127, -131072, 32767, 1'b1},
        '{MODE_SAMPLE, 0, 131071, -32768, 1'b1},
        '{2'd3, 127, -131072, 32767, 1'b0},
        '{MODE_STAP, 127, 131071, -32768, 1'b0},
        '{MODE_ITAP, 127, -131072, 0, 1'b0},
        '{MODE_STAP, 0, 131071, 0, 1'b0},
        '{MODE_STAP, 63, -131072, 0, 1'b0},
        '{MODE_STAP, 1, -131072, 0, 1'b0},
        '{MODE_ITAP, 0, 131071, 0, 1'b0},
        '{MODE_ITAP, 1, -131072, 0, 1'b0},
        '{MODE_ITAP, 2, 40000, 0, 1'b0},
        '{MODE_ITAP, 64, 5000, 0, 1'b0},
        '{MODE_SAMPLE, 127, -1, 32767, 1'b0},
        '{MODE_SAMPLE, 0, 0, -32768, 1'b0},
        '{MODE_SAMPLE, 85, 43690, 0, 1'b0},
        '{MODE_SAMPLE, 42, -43691, 12345, 1'b0},
        '{MODE_SAMPLE, 127, -1, -1, 1'b0},
        '{MODE_SAMPLE, 0, 0, 32767, 1'b0}
    };

    initial begin
        int r;
        logic [6:0] idx;
        logic signed [15:0] smp;
        n_err = 0;
        n_items = 0;
        n_outputs = 0;
        long_hold_req = 1'b0;
        no_idle = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        in_ch.valid = 1'b0; in_ch.mode = MODE_SAMPLE; in_ch.tap_index = '0;
        in_ch.tap_value = '0; in_ch.sample = '0;
        gain_reg = MOD_GAIN_RST; interp_reg = INTERP_RST; ntaps_reg = SHAPE_TAPS_RST;
        phase = '0;
        foreach (msg_hist[k]) msg_hist[k] = '0;
        foreach (shape_coef[k]) shape_coef[k] = '0;
        foreach (interp_coef[k]) interp_coef[k] = '0;
        foreach (cplx_i[k]) begin cplx_i[k] = '0; cplx_q[k] = '0; end
        i_rst_n = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[n])
            send(dir_rows[n].mode, 7'(dir_rows[n].idx), 18'(dir_rows[n].tap),
                 16'(dir_rows[n].smp), dir_rows[n].zero_out);

        for (int ph = 0; ph < 5; ph++) begin
            drain();
            case (ph)
                0: begin reg_write(REG_MOD_GAIN, 32'hFFFF); reg_write(REG_INTERP, 16);
                         reg_write(REG_SHAPE_TAPS, 64); end
                1: begin reg_write(REG_MOD_GAIN, 0); reg_write(REG_INTERP, 31);
                         reg_write(REG_SHAPE_TAPS, 0); end
                2: begin reg_write(REG_MOD_GAIN, $urandom); reg_write(REG_INTERP, 0);
                         reg_write(REG_SHAPE_TAPS, 127); end
                3: begin reg_write(REG_MOD_GAIN, 1); reg_write(REG_INTERP, 1);
                         reg_write(REG_SHAPE_TAPS, 1); end
                default: begin reg_write(REG_MOD_GAIN, $urandom);
                         reg_write(REG_INTERP, $urandom_range(1, 16));
                         reg_write(REG_SHAPE_TAPS, $urandom_range(1, 64)); end
            endcase
            if (ph == 0) long_hold_req = 1'b1;
            no_idle = (ph == 3);
            for (int n = 0; n < 90; n++) begin
                r = $urandom_range(0, 99);
                idx = (r % 2) ? 7'($urandom_range(0, 127)) : 7'($urandom_range(0, 70));
                smp = 16'($urandom);
                if ($urandom_range(0, 9) == 0) smp = ($urandom_range(0, 1)) ? 16'sh7FFF : 16'sh8000;
                if (r < 4)       send(2'd3, idx, 18'($urandom), smp, 1'b0);
                else if (r < 24) send(MODE_STAP, idx, 18'($urandom), smp, 1'b0);
                else if (r < 44) send(MODE_ITAP, idx, 18'($urandom), smp, 1'b0);
                else             send(MODE_SAMPLE, 7'($urandom), 18'($urandom), smp, 1'b0);
            end
        end
        no_idle = 1'b0;
        drain();

        $display("Ran %0d requests over 6 register settings, %0d outputs checked.",
                 n_items, n_outputs);
        if (n_err == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("%0d errors", n_err);
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
